/* design/tsac_pkg.sv */
// Package with shared constants for the TCP sender congestion block.
`default_nettype none
package tsac_pkg;
    localparam int unsigned SEQ_W  = 31;
    localparam int unsigned WIN_W  = 23;
    localparam int unsigned TIME_W = 28;
    localparam int unsigned LEN_W  = 11;
    localparam int unsigned SH_W   = 3;

    localparam logic [WIN_W-1:0]  ONE_SEG       = 23'd65536;
    localparam logic [WIN_W-1:0]  TWO_SEG       = 23'd131072;
    localparam logic [WIN_W-1:0]  SSTHRESH_INIT = 23'd4194304;
    localparam logic [TIME_W-1:0] RTO_MIN       = 28'd1000000;
    localparam logic [TIME_W-1:0] RTO_MAX       = 28'd240000000;
    localparam logic [TIME_W-1:0] RTO_INIT      = 28'd3000000;

    localparam logic CMD_ACK     = 1'b0;
    localparam logic CMD_TIMEOUT = 1'b1;

    localparam logic [0:0] REG_ALPHA = 1'b0;
    localparam logic [0:0] REG_BETA  = 1'b1;
endpackage
`default_nettype wire

/* design/tcp_sender_ack_congestion_rto.sv */
// Top level of the TCP sender ACK, congestion window and RTO block.
//
// Usage: one event item enters on the input channel (i_valid/o_ready) and one
// result item leaves on the output channel (o_valid/i_ready). An acknowledgment
// or a timeout is applied to the sender state and the new state is reported.
// Configuration registers alpha_shift (index 0) and beta_shift (index 1) are
// written through i_cfg_we, i_cfg_index and i_cfg_data; the user must write them
// only while the block is idle, which the block itself does not enforce.
// For a timeout or a duplicate the block goes from acceptance straight to the
// output stage. A new ACK passes through the RTT and RTO update states when it
// carries an RTT sample, then through the window update. In congestion
// avoidance the window update waits for the serial divider for 2^32/cwnd (one
// quotient bit per cycle). The block handles one item at a time: o_ready is low
// from acceptance until the result item has been taken, so a new item is not
// accepted before then.
// If the receiver stalls, the result is held in the output registers until
// i_ready is seen high. Reset clears all sender state to its initial values
// (window one segment, threshold 64 segments, RTO 3 s) and the gains to 3 and 2.
`default_nettype none
module tcp_sender_ack_congestion_rto #(
    parameter int unsigned SEGMENT_BYTES = 1024,
    parameter int unsigned MAX_WINDOW    = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [2:0]  i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_cmd,
    input  wire logic [30:0] i_ack_number,
    input  wire logic [10:0] i_acked_length,
    input  wire logic [27:0] i_rtt_sample_us,
    input  wire logic        i_sample_retransmitted,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [30:0]      o_base_seq,
    output logic [30:0]      o_window_limit,
    output logic [22:0]      o_cwnd_q16,
    output logic [22:0]      o_ssthresh_q16,
    output logic             o_in_avoidance,
    output logic [27:0]      o_rto_us,
    output logic             o_retransmit_base,
    output logic             o_restart_timer,
    output logic             o_was_duplicate
);
    localparam int unsigned CAP_RAW = MAX_WINDOW * 65536;
    localparam logic [22:0] WIN_CAP = (CAP_RAW > 8388607) ? 23'h7FFFFF : 23'(CAP_RAW);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RTT  = 3'd1;
    localparam logic [2:0] S_RTO  = 3'd2;
    localparam logic [2:0] S_WIN  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_LIM  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]  r_state;
    logic [2:0]  r_alpha, r_beta;
    logic [30:0] r_base, r_dup_val, r_ack;
    logic [1:0]  r_dup_cnt;
    logic [22:0] r_cwnd, r_ssth;
    logic        r_avoid;
    logic [27:0] r_srtt, r_dev, r_rto, r_sample;
    logic [10:0] r_len;
    logic        r_retx, r_restart, r_dup;
    logic        r_div_start;
    logic        w_div_done;
    logic [23:0] w_div_q;
    logic [31:0] w_limit;
    logic [27:0] w_diff;
    logic [28:0] w_dev_n, w_srtt_n;
    logic [30:0] w_rto_sum;
    logic [24:0] w_grow;

    tsac_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_div_start),
        .i_divisor(r_cwnd),
        .o_done   (w_div_done),
        .o_quot   (w_div_q)
    );

    // Jacobson update terms, worked in one step from registered state.
    assign w_diff    = (r_srtt > r_sample) ? r_srtt - r_sample : r_sample - r_srtt;
    assign w_dev_n   = {1'b0, r_dev - (r_dev >> r_beta)} + {1'b0, w_diff >> r_beta};
    assign w_srtt_n  = {1'b0, r_srtt - (r_srtt >> r_alpha)} + {1'b0, r_sample >> r_alpha};
    assign w_rto_sum = {3'b000, r_srtt} + {1'b0, r_dev, 2'b00};
    assign w_grow    = r_avoid ? {2'b00, r_cwnd} + {1'b0, w_div_q}
                               : {2'b00, r_cwnd} + {2'b00, tsac_pkg::ONE_SEG};
    assign w_limit   = {1'b0, r_base} + 32'(32'(r_cwnd[22:16]) * SEGMENT_BYTES);

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_alpha     <= 3'd3;
            r_beta      <= 3'd2;
            r_base      <= '0;
            r_dup_val   <= '0;
            r_dup_cnt   <= '0;
            r_cwnd      <= tsac_pkg::ONE_SEG;
            r_ssth      <= tsac_pkg::SSTHRESH_INIT;
            r_avoid     <= 1'b0;
            r_srtt      <= '0;
            r_dev       <= '0;
            r_rto       <= tsac_pkg::RTO_INIT;
            o_valid     <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_index == tsac_pkg::REG_ALPHA) r_alpha <= i_cfg_data;
                else r_beta <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_ack     <= i_ack_number;
                        r_len     <= i_acked_length;
                        r_sample  <= i_rtt_sample_us;
                        r_retx    <= 1'b0;
                        r_restart <= 1'b0;
                        r_dup     <= 1'b0;
                        if (i_cmd == tsac_pkg::CMD_TIMEOUT) begin
                            r_rto     <= (r_rto > (tsac_pkg::RTO_MAX >> 1))
                                         ? tsac_pkg::RTO_MAX : {r_rto[26:0], 1'b0};
                            r_retx    <= 1'b1;
                            r_restart <= 1'b1;
                            r_state   <= S_LIM;
                        end else if (i_ack_number < r_base) begin
                            r_dup   <= 1'b1;
                            r_state <= S_LIM;
                            if (r_dup_val == i_ack_number) begin
                                if (r_dup_cnt == 2'd2) begin
                                    r_ssth    <= ({1'b0, r_cwnd[22:1]} < tsac_pkg::TWO_SEG)
                                                 ? tsac_pkg::TWO_SEG : {1'b0, r_cwnd[22:1]};
                                    r_cwnd    <= tsac_pkg::ONE_SEG;
                                    r_avoid   <= 1'b0;
                                    r_retx    <= 1'b1;
                                    r_dup_cnt <= 2'd0;
                                end else begin
                                    r_dup_cnt <= r_dup_cnt + 2'd1;
                                end
                            end else begin
                                r_dup_val <= i_ack_number;
                                r_dup_cnt <= 2'd1;
                            end
                        end else begin
                            r_restart <= 1'b1;
                            r_state   <= (!i_sample_retransmitted && i_rtt_sample_us != '0)
                                         ? S_RTT : S_WIN;
                        end
                    end
                end
                S_RTT: begin
                    if (r_srtt == '0) begin
                        r_srtt <= r_sample;
                        r_dev  <= r_sample >> 1;
                    end else begin
                        r_srtt <= w_srtt_n[27:0];
                        r_dev  <= w_dev_n[27:0];
                    end
                    r_state <= S_RTO;
                end
                S_RTO: begin
                    if (w_rto_sum < {3'b000, tsac_pkg::RTO_MIN}) r_rto <= tsac_pkg::RTO_MIN;
                    else if (w_rto_sum > {3'b000, tsac_pkg::RTO_MAX}) r_rto <= tsac_pkg::RTO_MAX;
                    else r_rto <= w_rto_sum[27:0];
                    r_state <= S_WIN;
                end
                S_WIN: begin
                    r_base <= r_ack + {20'd0, r_len};
                    if (r_avoid && r_cwnd != '0) begin
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV;
                    end else begin
                        if (!r_avoid) begin
                            if (w_grow > {2'b00, WIN_CAP}) begin
                                r_cwnd <= WIN_CAP;
                                if (WIN_CAP >= r_ssth) r_avoid <= 1'b1;
                            end else begin
                                r_cwnd <= w_grow[22:0];
                                if (w_grow[22:0] >= r_ssth) r_avoid <= 1'b1;
                            end
                        end
                        r_state <= S_LIM;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_cwnd  <= (w_grow > {2'b00, WIN_CAP}) ? WIN_CAP : w_grow[22:0];
                        r_state <= S_LIM;
                    end
                end
                S_LIM: begin
                    o_base_seq     <= r_base;
                    o_window_limit <= w_limit[31] ? 31'h7FFFFFFF : w_limit[30:0];
                    o_valid        <= 1'b1;
                    r_state        <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cwnd_q16        = r_cwnd;
    assign o_ssthresh_q16    = r_ssth;
    assign o_in_avoidance    = r_avoid;
    assign o_rto_us          = r_rto;
    assign o_retransmit_base = r_retx;
    assign o_restart_timer   = r_restart;
    assign o_was_duplicate   = r_dup;
endmodule
`default_nettype wire

/* design/tsac_div.sv */
// Restoring divider computing floor(2^32 / divisor) one quotient bit a cycle.
`default_nettype none
module tsac_div (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [tsac_pkg::WIN_W-1:0] i_divisor,
    output logic                          o_done,
    output logic [tsac_pkg::WIN_W:0]      o_quot
);
    // Quotient of 2^32 by a divisor of at least 2^16 needs 17 bits.
    logic [tsac_pkg::WIN_W:0]   r_rem;
    logic [tsac_pkg::WIN_W:0]   r_quot;
    logic [5:0]                 r_cnt;
    logic                       r_busy;
    logic [tsac_pkg::WIN_W-1:0] r_div;
    logic [tsac_pkg::WIN_W+1:0] w_shift;
    logic                       w_ge;

    // Dividend bits: a single one at bit 32, zeros below.
    assign w_shift = {r_rem, (r_cnt == 6'd33)};
    assign w_ge    = w_shift >= {2'b00, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd33;
                r_rem  <= '0;
                r_quot <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem  <= w_ge ? w_shift[tsac_pkg::WIN_W:0] - {1'b0, r_div}
                               : w_shift[tsac_pkg::WIN_W:0];
                r_quot <= {r_quot[tsac_pkg::WIN_W-1:0], w_ge};
                r_cnt  <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quot = r_quot;
endmodule
`default_nettype wire

/* design/tsac_checker.sv */
// Port-level assertions for the TCP sender block, with their bind.
`default_nettype none
module tsac_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [27:0] o_rto_us,
    input wire logic        o_retransmit_base,
    input wire logic        o_restart_timer,
    input wire logic        o_was_duplicate
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_rto_us))
        else $error("result changed while stalled");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("ready while result pending");
    a_rto: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_rto_us >= 28'd1000000 && o_rto_us <= 28'd240000000)
        else $error("rto out of range");
    a_dup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_was_duplicate |-> !o_restart_timer)
        else $error("duplicate restarted timer");
    a_retx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_retransmit_base |-> o_restart_timer || o_was_duplicate)
        else $error("retransmit without timeout or duplicate");
endmodule

bind tcp_sender_ack_congestion_rto tsac_checker u_tsac_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_rto_us(o_rto_us),
    .o_retransmit_base(o_retransmit_base), .o_restart_timer(o_restart_timer),
    .o_was_duplicate(o_was_duplicate)
);
`default_nettype wire

/* test/tcp_sender_ack_congestion_rto_tb.sv */
// Self-checking testbench for the TCP sender ACK, congestion window and RTO block.
`default_nettype none
module tcp_sender_ack_congestion_rto_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SEG_BYTES = 1024;
    localparam int unsigned MAX_WIN   = 64;
    localparam longint unsigned LIMIT_CYCLES = 1000000;

    typedef struct packed {
        logic        cmd;
        logic [30:0] ack;
        logic [10:0] len;
        logic [27:0] rtt;
        logic        retx;
    } t_event;

    typedef struct packed {
        logic [30:0] base;
        logic [30:0] limit;
        logic [22:0] cwnd;
        logic [22:0] ssth;
        logic        avoid;
        logic [27:0] rto;
        logic        retx;
        logic        restart;
        logic        dup;
    } t_status;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_index = tsac_pkg::REG_ALPHA;
    logic [2:0]  i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        i_cmd = tsac_pkg::CMD_ACK;
    logic [30:0] i_ack_number = '0;
    logic [10:0] i_acked_length = '0;
    logic [27:0] i_rtt_sample_us = '0;
    logic        i_sample_retransmitted = 1'b0;
    logic        i_ready = 1'b0;
    logic        o_ready, o_valid, o_in_avoidance, o_retransmit_base;
    logic        o_restart_timer, o_was_duplicate;
    logic [30:0] o_base_seq, o_window_limit;
    logic [22:0] o_cwnd_q16, o_ssthresh_q16;
    logic [27:0] o_rto_us;

    tcp_sender_ack_congestion_rto #(.SEGMENT_BYTES(SEG_BYTES), .MAX_WINDOW(MAX_WIN)) u_dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data, .i_valid, .o_ready,
        .i_cmd, .i_ack_number, .i_acked_length, .i_rtt_sample_us,
        .i_sample_retransmitted, .o_valid, .i_ready, .o_base_seq, .o_window_limit,
        .o_cwnd_q16, .o_ssthresh_q16, .o_in_avoidance, .o_rto_us,
        .o_retransmit_base, .o_restart_timer, .o_was_duplicate
    );

    always #4 i_clk = ~i_clk;

    // Predictor state, a private copy of what the block should hold.
    logic [2:0]  gain_a, gain_b;
    logic [30:0] snd_base, dup_val;
    logic [1:0]  dup_cnt;
    logic [22:0] cwnd, ssthresh;
    logic        avoiding;
    logic [27:0] srtt, rttvar, rto;

    t_event  pending_events[$];
    t_status expected_status[$];

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_off = 1'b0;
    int  fail_count = 0;
    int  ack_count = 0, dup_count = 0, fast_retx_count = 0, timeout_count = 0;
    int  avoid_count = 0;
    longint unsigned cycles = 0;

    task automatic reset_predictor();
        gain_a = 3'd3; gain_b = 3'd2;
        snd_base = '0; dup_val = '0; dup_cnt = '0;
        cwnd = tsac_pkg::ONE_SEG; ssthresh = tsac_pkg::SSTHRESH_INIT; avoiding = 1'b0;
        srtt = '0; rttvar = '0; rto = tsac_pkg::RTO_INIT;
    endtask

    // Computes the sender's reported state after one event and updates the copy.
    function automatic t_status apply_event(t_event ev);
        t_status st;
        logic [63:0] w, cap, tmp, lim;
        logic [27:0] diff;
        st = '0;
        if (ev.cmd == tsac_pkg::CMD_TIMEOUT) begin
            tmp = 64'(rto) * 2;
            rto = (tmp > 64'(tsac_pkg::RTO_MAX)) ? tsac_pkg::RTO_MAX : tmp[27:0];
            st.retx = 1'b1;
            st.restart = 1'b1;
            timeout_count++;
        end else if (ev.ack < snd_base) begin
            st.dup = 1'b1;
            dup_count++;
            if (dup_val == ev.ack) begin
                dup_cnt = dup_cnt + 2'd1;
                if (dup_cnt == 2'd3) begin
                    // Third repeat: halve into the threshold and restart slow start.
                    ssthresh = ((cwnd >> 1) < tsac_pkg::TWO_SEG) ? tsac_pkg::TWO_SEG
                                                                 : (cwnd >> 1);
                    cwnd = tsac_pkg::ONE_SEG;
                    avoiding = 1'b0;
                    st.retx = 1'b1;
                    dup_cnt = '0;
                    fast_retx_count++;
                end
            end else begin
                dup_val = ev.ack;
                dup_cnt = 2'd1;
            end
        end else begin
            ack_count++;
            if (!ev.retx && ev.rtt != 0) begin
                if (srtt == 0) begin
                    srtt = ev.rtt;
                    rttvar = ev.rtt >> 1;
                end else begin
                    diff = (srtt > ev.rtt) ? srtt - ev.rtt : ev.rtt - srtt;
                    rttvar = rttvar - (rttvar >> gain_b) + (diff >> gain_b);
                    srtt = srtt - (srtt >> gain_a) + (ev.rtt >> gain_a);
                end
                tmp = 64'(srtt) + 4 * 64'(rttvar);
                if (tmp < 64'(tsac_pkg::RTO_MIN)) tmp = 64'(tsac_pkg::RTO_MIN);
                if (tmp > 64'(tsac_pkg::RTO_MAX)) tmp = 64'(tsac_pkg::RTO_MAX);
                rto = tmp[27:0];
            end
            cap = 64'(MAX_WIN) * 65536;
            if (cap > 64'h7FFFFF) cap = 64'h7FFFFF;
            w = 64'(cwnd);
            if (!avoiding) w = w + 65536;
            else if (w != 0) begin
                w = w + (64'h1_0000_0000 / w);
                avoid_count++;
            end
            if (w > cap) w = cap;
            cwnd = w[22:0];
            if (!avoiding && cwnd >= ssthresh) avoiding = 1'b1;
            snd_base = ev.ack + 31'(ev.len);
            st.restart = 1'b1;
        end
        lim = 64'(snd_base) + 64'(cwnd >> 16) * SEG_BYTES;
        if (lim > 64'h7FFF_FFFF) lim = 64'h7FFF_FFFF;
        st.base = snd_base;
        st.limit = lim[30:0];
        st.cwnd = cwnd;
        st.ssth = ssthresh;
        st.avoid = avoiding;
        st.rto = rto;
        return st;
    endfunction

    // Driver: offers the oldest pending item, keeping it steady until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !o_ready) begin
            // Still waiting for acceptance; hold the item.
        end else begin
            if (i_valid) begin
                expected_status.push_back(apply_event(pending_events.pop_front()));
            end
            if (pending_events.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_valid <= 1'b1;
                i_cmd <= pending_events[0].cmd;
                i_ack_number <= pending_events[0].ack;
                i_acked_length <= pending_events[0].len;
                i_rtt_sample_us <= pending_events[0].rtt;
                i_sample_retransmitted <= pending_events[0].retx;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor: compares each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_status got, want;
        cycles <= cycles + 1;
        if (i_rst_n) begin
            i_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
            if (o_valid && i_ready) begin
                got = '{o_base_seq, o_window_limit, o_cwnd_q16, o_ssthresh_q16,
                        o_in_avoidance, o_rto_us, o_retransmit_base,
                        o_restart_timer, o_was_duplicate};
                if (expected_status.size() == 0) begin
                    $display("%0t: result with nothing expected, got %h", $time, got);
                    fail_count++;
                end else begin
                    want = expected_status.pop_front();
                    if (got.base != want.base)
                        $display("%0t: base_seq exp %0d act %0d", $time, want.base, got.base);
                    if (got.limit != want.limit)
                        $display("%0t: window_limit exp %0d act %0d", $time, want.limit,
                                 got.limit);
                    if (got.cwnd != want.cwnd)
                        $display("%0t: cwnd exp %0d act %0d", $time, want.cwnd, got.cwnd);
                    if (got.ssth != want.ssth)
                        $display("%0t: ssthresh exp %0d act %0d", $time, want.ssth, got.ssth);
                    if (got.avoid != want.avoid)
                        $display("%0t: in_avoidance exp %0d act %0d", $time, want.avoid,
                                 got.avoid);
                    if (got.rto != want.rto)
                        $display("%0t: rto exp %0d act %0d", $time, want.rto, got.rto);
                    if (got.retx != want.retx)
                        $display("%0t: retransmit exp %0d act %0d", $time, want.retx, got.retx);
                    if (got.restart != want.restart)
                        $display("%0t: restart exp %0d act %0d", $time, want.restart,
                                 got.restart);
                    if (got.dup != want.dup)
                        $display("%0t: duplicate exp %0d act %0d", $time, want.dup, got.dup);
                    if (got != want) fail_count++;
                end
            end
        end
        if (cycles > LIMIT_CYCLES) begin
            $display("%0t: timeout, %0d results outstanding", $time, expected_status.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Waits until every item has been taken and every result has arrived.
    task automatic drain();
        while (pending_events.size() > 0 || i_valid || expected_status.size() > 0)
            @(posedge i_clk);
        // Idle margin before the next phase; no item is in flight at this point.
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_gain(logic [0:0] idx, logic [2:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == tsac_pkg::REG_ALPHA) gain_a = val;
        else gain_b = val;
    endtask

    function automatic t_event make_ack(logic [30:0] ack, logic [10:0] len,
                                        logic [27:0] rtt, logic retx);
        return '{tsac_pkg::CMD_ACK, ack, len, rtt, retx};
    endfunction

    // Random items: mostly well-formed traffic around the send base, some noise.
    task automatic queue_random(int count);
        t_event ev;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(9))
                0: ev = '{tsac_pkg::CMD_TIMEOUT, 31'($urandom), 11'($urandom),
                          28'($urandom), 1'($urandom)};
                1, 2: begin
                    // Burst of duplicates at one value, enough for a fast retransmit.
                    ev = make_ack(31'($urandom_range(2000)), 11'($urandom_range(1024)),
                                  '0, 1'b0);
                    repeat ($urandom_range(2, 4)) pending_events.push_back(ev);
                end
                3: ev = make_ack(31'($urandom), 11'($urandom_range(1024)), 28'($urandom),
                                 1'($urandom));
                default: ev = make_ack(31'($urandom_range(5000)), 11'($urandom_range(1024)),
                                       ($urandom_range(3) == 0) ? 28'd0 :
                                       28'($urandom_range(10000, 3000000)),
                                       $urandom_range(7) == 0);
            endcase
            pending_events.push_back(ev);
        end
    endtask

    initial begin
        reset_predictor();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, first sample, duplicates and a fast retransmit.
        pending_events.push_back('{tsac_pkg::CMD_TIMEOUT, 31'h7FFFFFFF, 11'h7FF,
                                   28'hFFFFFFF, 1'b1});
        pending_events.push_back(make_ack(31'd0, 11'd0, 28'd0, 1'b0));
        pending_events.push_back(make_ack(31'd100, 11'd1024, 28'd200000, 1'b0));
        pending_events.push_back(make_ack(31'd2000, 11'd1024, 28'hFFFFFFF, 1'b0));
        pending_events.push_back(make_ack(31'd3024, 11'd1, 28'd1, 1'b1));
        pending_events.push_back(make_ack(31'd3025, 11'd1024, 28'd1, 1'b0));
        for (int k = 0; k < 4; k++)
            pending_events.push_back(make_ack(31'd10, 11'd0, 28'd0, 1'b0));
        pending_events.push_back(make_ack(31'd11, 11'd0, 28'd0, 1'b0));
        for (int k = 0; k < 8; k++)
            pending_events.push_back('{tsac_pkg::CMD_TIMEOUT, 31'd0, 11'd0, 28'd0, 1'b0});
        for (int k = 0; k < 70; k++)
            pending_events.push_back(make_ack(31'd4049 + 31'(k), 11'd0,
                                              28'd1000, 1'b0));
        // Base wrap with the largest ack number and a length of 1024.
        pending_events.push_back(make_ack(31'h7FFFFFFF, 11'd1024, 28'd5, 1'b0));
        drain();

        // Gain extremes, then the random phases under different idling.
        write_gain(tsac_pkg::REG_ALPHA, 3'd0);
        write_gain(tsac_pkg::REG_BETA, 3'd7);
        send_idle_pct = 59;
        queue_random(180);
        drain();
        write_gain(tsac_pkg::REG_ALPHA, 3'd7);
        write_gain(tsac_pkg::REG_BETA, 3'd0);
        send_idle_pct = 0; recv_stall_pct = 59;
        queue_random(180);
        drain();
        write_gain(tsac_pkg::REG_ALPHA, 3'd1);
        write_gain(tsac_pkg::REG_BETA, 3'd1);
        send_idle_pct = 33; recv_stall_pct = 33;
        queue_random(180);
        drain();
        write_gain(tsac_pkg::REG_ALPHA, 3'd3);
        write_gain(tsac_pkg::REG_BETA, 3'd2);
        send_idle_pct = 0; recv_stall_pct = 0;
        queue_random(180);
        // Long receiver hold-off while items keep being offered.
        hold_off = 1'b1;
        repeat (300) @(posedge i_clk);
        hold_off = 1'b0;
        drain();
        send_idle_pct = 20; recv_stall_pct = 20;
        queue_random(180);
        drain();

        $display("Covered %0d new ACKs (%0d in avoidance), %0d duplicates,", ack_count,
                 avoid_count, dup_count);
        $display("%0d fast retransmits and %0d timeouts across four gain settings.",
                 fast_retx_count, timeout_count);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* tcp_sender_ack_congestion_rto.f */
design/tsac_pkg.sv
design/tsac_div.sv
design/tcp_sender_ack_congestion_rto.sv
design/tsac_checker.sv
test/tcp_sender_ack_congestion_rto_tb.sv
